@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Expects clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge out of reset.
`define SITOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in a cycle implies a condition in the next.
`define SITOA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/core/sitoa_pkg.sv @@
// Package for the signed integer to decimal ASCII unit.
// Widths, character codes, result struct and the double-dabble step.
`timescale 1ns / 1ps

package sitoa_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int IN_WIDTH        = 32;
  localparam int CHAR_WIDTH      = 6;
  localparam int DIGITS          = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BCD_WIDTH       = DIGITS * 4;
  localparam int DIG_IDX_W       = $clog2(DIGITS);
  localparam int SHIFT_WIDTH     = BCD_WIDTH + VALUE_WIDTH;
  localparam int STEPS_PER_STAGE = 8;
  localparam int DD_STAGES       = (VALUE_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;
  localparam logic [3:0]            RADIX      = 4'd10;
  localparam logic [3:0]            DD_THRESH  = 4'd5;
  localparam logic [3:0]            DD_ADJ     = 4'd3;

  typedef struct packed {
    logic                 neg;
    logic [BCD_WIDTH-1:0] bcd;
    logic [DIG_IDX_W-1:0] top;
  } sitoa_num_t;

  // One double-dabble iteration: adjust every BCD digit, then shift left.
  function automatic logic [SHIFT_WIDTH-1:0] dd_step(input logic [SHIFT_WIDTH-1:0] s);
    logic [SHIFT_WIDTH-1:0] t;
    t = s;
    for (int d = 0; d < DIGITS; d++) begin
      if (t[VALUE_WIDTH + 4*d +: 4] >= DD_THRESH) begin
        t[VALUE_WIDTH + 4*d +: 4] = t[VALUE_WIDTH + 4*d +: 4] + DD_ADJ;
      end
    end
    return {t[SHIFT_WIDTH-2:0], 1'b0};
  endfunction

endpackage

@@ rtl/core/sitoa_if.sv @@
// Valid/ready channel interfaces for the integer to ASCII unit.
// Depends on sitoa_pkg.
`timescale 1ns / 1ps

interface sitoa_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sitoa_pkg::IN_WIDTH-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitoa_out_if;
  logic                                valid;
  logic                                ready;
  logic [sitoa_pkg::CHAR_WIDTH-1:0]    text_char;
  logic                                last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

@@ rtl/core/sitoa_bcd_pipe.sv @@
// Binary magnitude to BCD pipeline: sign strip, staged double dabble,
// leading digit search. Depends on sitoa_pkg.
`timescale 1ns / 1ps

module sitoa_bcd_pipe (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sitoa_pkg::VALUE_WIDTH-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sitoa_pkg::sitoa_num_t               out_num
);

  localparam int VW = sitoa_pkg::VALUE_WIDTH;
  localparam int SW = sitoa_pkg::SHIFT_WIDTH;
  localparam int NS = sitoa_pkg::DD_STAGES;
  localparam int SP = sitoa_pkg::STEPS_PER_STAGE;

  logic          v_r   [0:NS];
  logic          neg_r [0:NS];
  logic [SW-1:0] sh_r  [0:NS];
  logic [SW-1:0] sh_nxt[1:NS];
  logic          adv   [0:NS];

  logic                            vf_r;
  logic                            advf;
  sitoa_pkg::sitoa_num_t           num_r;
  logic [sitoa_pkg::DIG_IDX_W-1:0] top_nxt;
  logic                            neg_in;
  logic [VW-1:0]                   mag_in;

  assign advf = !vf_r || out_ready;

  always_comb begin
    adv[NS] = !v_r[NS] || advf;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_comb begin
    logic [SW-1:0] s;
    for (int k = 1; k <= NS; k++) begin
      s = sh_r[k-1];
      for (int i = 0; i < SP; i++) begin
        if ((k-1) * SP + i < VW) begin
          s = sitoa_pkg::dd_step(s);
        end
      end
      sh_nxt[k] = s;
    end
  end

  assign in_ready = adv[0];
  assign neg_in   = in_value[VW-1];
  assign mag_in   = neg_in ? (~in_value + VW'(1)) : in_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NS; k++) begin
        v_r[k] <= 1'b0;
      end
      vf_r <= 1'b0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k <= NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (advf) begin
        vf_r <= v_r[NS];
      end
    end
  end

  // Highest nonzero digit; zero keeps index 0 so one '0' is sent.
  always_comb begin
    top_nxt = '0;
    for (int d = 0; d < sitoa_pkg::DIGITS; d++) begin
      if (sh_r[NS][VW + 4*d +: 4] != 4'd0) begin
        top_nxt = sitoa_pkg::DIG_IDX_W'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && adv[0]) begin
      sh_r[0]  <= {{sitoa_pkg::BCD_WIDTH{1'b0}}, mag_in};
      neg_r[0] <= neg_in;
    end
    for (int k = 1; k <= NS; k++) begin
      if (adv[k] && v_r[k-1]) begin
        sh_r[k]  <= sh_nxt[k];
        neg_r[k] <= neg_r[k-1];
      end
    end
    if (advf && v_r[NS]) begin
      num_r.neg <= neg_r[NS];
      num_r.bcd <= sh_r[NS][SW-1:VW];
      num_r.top <= top_nxt;
    end
  end

  assign out_valid = vf_r;
  assign out_num   = num_r;

endmodule

@@ rtl/core/signed_int_to_decimal_ascii_unit.sv @@
// Signed integer to decimal ASCII unit, top level.
// Depends on sitoa_pkg, sitoa_if, sitoa_bcd_pipe and assert_macros.svh.
//
// Each accepted item is a signed integer; the unit sends its decimal text
// one character per result item, minus sign first when negative, no leading
// zeros, last_char set on the final character. A number has 1 to 11
// characters at 32 bits, and the next number's text is loaded as the last
// character of the one before is taken. The character serializer at the
// output sends one character per cycle while out_ch.ready is high. From
// an accepted item to its first character the path runs through the input
// register, four double-dabble stages of eight shifts each, the leading
// digit search and the serializer register. The conversion pipeline keeps
// taking items while the serializer is busy until it fills up.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module signed_int_to_decimal_ascii_unit (
  input  logic              clk,
  input  logic              rst_n,
  sitoa_in_if.sink          in_ch,
  sitoa_out_if.source       out_ch
);

  logic                                pipe_valid;
  logic                                pipe_ready;
  sitoa_pkg::sitoa_num_t               pipe_num;

  logic                                busy_r, busy_nxt;
  logic                                sign_r, sign_nxt;
  logic [sitoa_pkg::DIG_IDX_W-1:0]     idx_r, idx_nxt;
  logic [sitoa_pkg::BCD_WIDTH-1:0]     digits_r;
  logic [3:0]                          cur_digit;
  logic                                last;
  logic                                out_hs;
  logic                                done;
  logic                                load;

  sitoa_bcd_pipe u_bcd_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_value  (in_ch.value[sitoa_pkg::VALUE_WIDTH-1:0]),
    .out_valid (pipe_valid),
    .out_ready (pipe_ready),
    .out_num   (pipe_num)
  );

  assign cur_digit  = digits_r[{idx_r, 2'b00} +: 4];
  assign last       = !sign_r && (idx_r == '0);
  assign out_hs     = busy_r && out_ch.ready;
  assign done       = out_hs && last;
  assign pipe_ready = !busy_r || done;
  assign load       = pipe_valid && pipe_ready;

  always_comb begin
    busy_nxt = busy_r;
    sign_nxt = sign_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      sign_nxt = pipe_num.neg;
      idx_nxt  = pipe_num.top;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (out_hs) begin
      if (sign_r) begin
        sign_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      sign_r <= sign_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits_r <= pipe_num.bcd;
    end
  end

  assign out_ch.valid     = busy_r;
  assign out_ch.text_char = sign_r ? sitoa_pkg::CHAR_MINUS
                                   : sitoa_pkg::CHAR_ZERO + {2'b00, cur_digit};
  assign out_ch.last_char = last;

  `SITOA_ASSERT(a_sign_not_last, out_ch.valid && sign_r |-> !out_ch.last_char, "minus sign marked last")
  `SITOA_ASSERT(a_digit_bcd, busy_r && !sign_r |-> cur_digit < sitoa_pkg::RADIX, "digit out of range")
  `SITOA_ASSERT_NEXT(a_run_continues, out_hs && !last, busy_r, "text cut short")
  `SITOA_ASSERT_NEXT(a_run_ends, done && !pipe_valid, !busy_r, "text runs past last char")

endmodule
